// File: rtl/dls_pkg.sv
// ----------------------------------------------------------------------------
// dls_pkg
// Shared widths, reset values, register codes and helpers for the distance
// LOD selector.
// ----------------------------------------------------------------------------
package dls_pkg;

	localparam int COORD_W    = 21;
	localparam int TIME_W     = 32;
	localparam int NUM_W      = 32;
	localparam int LOD_W      = 3;
	localparam int THR_W      = 16;
	localparam int IVL_W      = 12;
	localparam int SKEL_W     = 16;
	localparam int MAXVIS_W   = 20;
	localparam int VCNT_W     = 2;
	localparam int VIEW_W     = 3 * COORD_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam int LOD_THRESHOLDS = 4;
	localparam int INTERVAL_SLOTS = 5;
	localparam int MAX_VIEWS      = 2;
	localparam int SLOT_W         = $clog2(INTERVAL_SLOTS);

	localparam int ABS_W  = COORD_W;
	localparam int SQ_W   = 2 * ABS_W;
	localparam int DIST_W = SQ_W + 2;

	localparam int MOD_W     = 5;
	localparam int JIT_W     = 9;
	localparam int JIT_BASE  = 255;
	localparam int JIT_STEP  = 3;
	localparam int JIT_MOD   = 31;
	localparam int PROD_W    = IVL_W + JIT_W;
	// floor(x / 300) == (x * RECIP) >> RECIP_SHIFT for all x below 2^PROD_W
	localparam int RECIP_W     = 24;
	localparam int RECIP_SHIFT = 32;
	localparam logic [RECIP_W-1:0] RECIP = 24'd14316558;
	localparam int SCALED_W    = PROD_W + RECIP_W;
	localparam int QUOT_W      = SCALED_W - RECIP_SHIFT;

	localparam logic [4*THR_W-1:0]          RST_LOD_THR  = 64'h1770_0BB8_05DC_01F4;
	localparam logic [INTERVAL_SLOTS*IVL_W-1:0] RST_IVL_TAB = 60'h3E8_1F4_0C8_064_032;
	localparam logic [SKEL_W-1:0]           RST_SKEL     = 16'd300;
	localparam logic [MAXVIS_W-1:0]         RST_MAXVIS   = 20'd10000;
	localparam logic [VCNT_W-1:0]           RST_VCNT     = 2'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_LOD_THR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IVL_TAB = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SKEL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAXVIS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_VCNT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_A  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_B  = 3'd6;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [ABS_W-1:0]          absd_t;
	typedef logic [DIST_W-1:0]         dist_t;

	// 2^5 == 1 mod 31, so fold 5-bit digits twice and correct once
	function automatic logic [MOD_W-1:0] mod31(input logic [NUM_W-1:0] n);
		logic [7:0] s;
		logic [5:0] f;
		s = 8'(n[4:0]) + 8'(n[9:5]) + 8'(n[14:10]) + 8'(n[19:15])
			+ 8'(n[24:20]) + 8'(n[29:25]) + 8'(n[31:30]);
		f = 6'(s[4:0]) + 6'(s[7:5]);
		if (f >= 6'(JIT_MOD)) begin
			f = f - 6'(JIT_MOD);
		end
		return f[MOD_W-1:0];
	endfunction

endpackage

// File: rtl/distance_lod_selector_unit.sv
// ----------------------------------------------------------------------------
// distance_lod_selector_unit
// Per-entity LOD level, visibility, skeletal-mesh choice and next due time.
// ----------------------------------------------------------------------------
// One entity word enters per cycle while in_stall is low, and its result word is
// presented once it has passed the input register, seven compute stages and the
// result register. Throughput is one word per clock when the result side does not
// stall; the depth comes from the squaring and reciprocal multipliers each having a
// stage of their own. A stalled result holds its stage while empty stages upstream
// keep filling. Squared thresholds and cutoffs are registered copies of the
// configuration, valid in the cycle after the configuration register takes a write.
module distance_lod_selector_unit
	import dls_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_W-1:0]    pos_x,
	input  logic [COORD_W-1:0]    pos_y,
	input  logic [COORD_W-1:0]    pos_z,
	input  logic [NUM_W-1:0]      entity_number,
	input  logic                  has_skeletal_mesh,
	input  logic [TIME_W-1:0]     due_time,
	input  logic [TIME_W-1:0]     now_time,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  refreshed,
	output logic [LOD_W-1:0]      lod_level,
	output logic                  visible,
	output logic                  skeletal_on,
	output logic [TIME_W-1:0]     next_due_time
);

	localparam int NSTG = 9;

	// configuration
	logic [4*THR_W-1:0]                lod_thr_q;
	logic [INTERVAL_SLOTS*IVL_W-1:0]   ivl_tab_q;
	logic [SKEL_W-1:0]                 skel_q;
	logic [MAXVIS_W-1:0]               maxvis_q;
	logic [VCNT_W-1:0]                 vcnt_q;
	logic [VIEW_W-1:0]                 view_a_q;
	logic [VIEW_W-1:0]                 view_b_q;

	logic [2*THR_W-1:0]                thr_sq_q [LOD_THRESHOLDS];
	logic [2*SKEL_W-1:0]               skel_sq_q;
	logic [2*MAXVIS_W-1:0]             vis_sq_q;
	logic                              vis_all_q;

	logic [VIEW_W-1:0]                 views [MAX_VIEWS];
	logic [IVL_W-1:0]                  ivl_arr [INTERVAL_SLOTS];
	logic [MAX_VIEWS-1:0]              view_act;

	// handshake
	logic [NSTG-1:0]                   vld_q;
	logic [NSTG-1:0]                   adv;

	// s1
	coord_t                            pos_s1 [3];
	logic [NUM_W-1:0]                  num_s1;
	logic                              mesh_s1;
	logic [TIME_W-1:0]                 due_s1;
	logic [TIME_W-1:0]                 now_s1;
	absd_t                             absd_c [MAX_VIEWS][3];

	// s2
	absd_t                             absd_s2 [MAX_VIEWS][3];
	logic                              refresh_s2;
	logic [TIME_W-1:0]                 base_s2;
	logic                              mesh_s2;
	logic [MOD_W-1:0]                  mod_s2;

	// s3
	logic [SQ_W-1:0]                   sq_s3 [MAX_VIEWS][3];
	logic                              refresh_s3;
	logic [TIME_W-1:0]                 base_s3;
	logic                              mesh_s3;
	logic [JIT_W-1:0]                  jit_s3;

	// s4
	dist_t                             dist_s4 [MAX_VIEWS];
	logic                              refresh_s4;
	logic [TIME_W-1:0]                 base_s4;
	logic                              mesh_s4;
	logic [JIT_W-1:0]                  jit_s4;
	dist_t                             best_c;

	// s5
	dist_t                             best_s5;
	logic                              refresh_s5;
	logic [TIME_W-1:0]                 base_s5;
	logic                              mesh_s5;
	logic [JIT_W-1:0]                  jit_s5;
	logic [LOD_W-1:0]                  lod_c;
	logic [SLOT_W-1:0]                 slot_c;
	logic                              vis_c;
	logic                              skel_c;

	// s6
	logic                              refresh_s6;
	logic [TIME_W-1:0]                 base_s6;
	logic [JIT_W-1:0]                  jit_s6;
	logic [LOD_W-1:0]                  lod_s6;
	logic                              vis_s6;
	logic                              skel_s6;
	logic [IVL_W-1:0]                  ivl_s6;

	// s7
	logic                              refresh_s7;
	logic [TIME_W-1:0]                 base_s7;
	logic [LOD_W-1:0]                  lod_s7;
	logic                              vis_s7;
	logic                              skel_s7;
	logic [PROD_W-1:0]                 prod_s7;

	// s8
	logic                              refresh_s8;
	logic [TIME_W-1:0]                 base_s8;
	logic [LOD_W-1:0]                  lod_s8;
	logic                              vis_s8;
	logic                              skel_s8;
	logic [SCALED_W-1:0]               scaled_s8;
	logic [QUOT_W-1:0]                 quot_c;
	logic [TIME_W:0]                   sum_c;

	// result
	logic                              refreshed_q;
	logic [LOD_W-1:0]                  lod_q;
	logic                              vis_q;
	logic                              skel_q2;
	logic [TIME_W-1:0]                 next_q;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lod_thr_q <= RST_LOD_THR;
			ivl_tab_q <= RST_IVL_TAB;
			skel_q    <= RST_SKEL;
			maxvis_q  <= RST_MAXVIS;
			vcnt_q    <= RST_VCNT;
			view_a_q  <= '0;
			view_b_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LOD_THR: lod_thr_q <= cfg_data;
				CFG_IVL_TAB: ivl_tab_q <= cfg_data[INTERVAL_SLOTS*IVL_W-1:0];
				CFG_SKEL:    skel_q    <= cfg_data[SKEL_W-1:0];
				CFG_MAXVIS:  maxvis_q  <= cfg_data[MAXVIS_W-1:0];
				CFG_VCNT:    vcnt_q    <= cfg_data[VCNT_W-1:0];
				CFG_VIEW_A:  view_a_q  <= cfg_data[VIEW_W-1:0];
				CFG_VIEW_B:  view_b_q  <= cfg_data[VIEW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LOD_THRESHOLDS; i++) begin
			thr_sq_q[i] <= lod_thr_q[i*THR_W +: THR_W] * lod_thr_q[i*THR_W +: THR_W];
		end
		skel_sq_q <= skel_q * skel_q;
		vis_sq_q  <= maxvis_q * maxvis_q;
		vis_all_q <= (maxvis_q == '0);
	end

	assign views[0] = view_a_q;
	assign views[1] = view_b_q;

	always_comb begin
		for (int i = 0; i < INTERVAL_SLOTS; i++) begin
			ivl_arr[i] = ivl_tab_q[i*IVL_W +: IVL_W];
		end
		for (int v = 0; v < MAX_VIEWS; v++) begin
			view_act[v] = (v == 0) || (vcnt_q > VCNT_W'(v));
		end
	end

	// ------------------------------------------------------------------
	// Stage flow
	// ------------------------------------------------------------------
	always_comb begin
		adv[NSTG-1] = !vld_q[NSTG-1] || !out_stall;
		for (int k = NSTG - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign in_stall = !adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// s1: input register, absolute differences, due check, jitter digit
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			pos_s1[0] <= pos_x;
			pos_s1[1] <= pos_y;
			pos_s1[2] <= pos_z;
			num_s1    <= entity_number;
			mesh_s1   <= has_skeletal_mesh;
			due_s1    <= due_time;
			now_s1    <= now_time;
		end
	end

	always_comb begin
		coord_t               vc;
		logic [COORD_W:0]     diff;
		logic [COORD_W:0]     mag;
		for (int v = 0; v < MAX_VIEWS; v++) begin
			for (int c = 0; c < 3; c++) begin
				vc   = views[v][c*COORD_W +: COORD_W];
				diff = {pos_s1[c][COORD_W-1], pos_s1[c]} - {vc[COORD_W-1], vc};
				mag  = diff[COORD_W] ? (~diff + 1'b1) : diff;
				absd_c[v][c] = mag[ABS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			absd_s2    <= absd_c;
			refresh_s2 <= (now_s1 >= due_s1);
			base_s2    <= (now_s1 >= due_s1) ? now_s1 : due_s1;
			mesh_s2    <= mesh_s1;
			mod_s2     <= mod31(num_s1);
		end
	end

	// ------------------------------------------------------------------
	// s2: squares, jitter factor
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int v = 0; v < MAX_VIEWS; v++) begin
				for (int c = 0; c < 3; c++) begin
					sq_s3[v][c] <= absd_s2[v][c] * absd_s2[v][c];
				end
			end
			refresh_s3 <= refresh_s2;
			base_s3    <= base_s2;
			mesh_s3    <= mesh_s2;
			jit_s3     <= JIT_W'(JIT_BASE) + JIT_W'(mod_s2) * JIT_W'(JIT_STEP);
		end
	end

	// ------------------------------------------------------------------
	// s3: squared distance per view
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int v = 0; v < MAX_VIEWS; v++) begin
				dist_s4[v] <= DIST_W'(sq_s3[v][0]) + DIST_W'(sq_s3[v][1])
					+ DIST_W'(sq_s3[v][2]);
			end
			refresh_s4 <= refresh_s3;
			base_s4    <= base_s3;
			mesh_s4    <= mesh_s3;
			jit_s4     <= jit_s3;
		end
	end

	// ------------------------------------------------------------------
	// s4: nearest active view
	// ------------------------------------------------------------------
	always_comb begin
		best_c = dist_s4[0];
		for (int v = 1; v < MAX_VIEWS; v++) begin
			if (view_act[v] && (dist_s4[v] < best_c)) begin
				best_c = dist_s4[v];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			best_s5    <= best_c;
			refresh_s5 <= refresh_s4;
			base_s5    <= base_s4;
			mesh_s5    <= mesh_s4;
			jit_s5     <= jit_s4;
		end
	end

	// ------------------------------------------------------------------
	// s5: level, visibility, skeletal mesh, interval pick
	// ------------------------------------------------------------------
	always_comb begin
		lod_c = LOD_W'(LOD_THRESHOLDS);
		for (int i = LOD_THRESHOLDS - 1; i >= 0; i--) begin
			if (best_s5 <= DIST_W'(thr_sq_q[i])) begin
				lod_c = LOD_W'(i);
			end
		end
		slot_c = (lod_c > LOD_W'(INTERVAL_SLOTS - 1)) ? SLOT_W'(INTERVAL_SLOTS - 1)
			: SLOT_W'(lod_c);
		vis_c  = vis_all_q || (best_s5 <= DIST_W'(vis_sq_q));
		skel_c = vis_c && mesh_s5 && (best_s5 <= DIST_W'(skel_sq_q));
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			refresh_s6 <= refresh_s5;
			base_s6    <= base_s5;
			jit_s6     <= jit_s5;
			lod_s6     <= lod_c;
			vis_s6     <= vis_c;
			skel_s6    <= skel_c;
			ivl_s6     <= ivl_arr[slot_c];
		end
	end

	// ------------------------------------------------------------------
	// s6: interval times jitter
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			refresh_s7 <= refresh_s6;
			base_s7    <= base_s6;
			lod_s7     <= lod_s6;
			vis_s7     <= vis_s6;
			skel_s7    <= skel_s6;
			prod_s7    <= ivl_s6 * jit_s6;
		end
	end

	// ------------------------------------------------------------------
	// s7: divide by 300 through the reciprocal
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv[7]) begin
			refresh_s8 <= refresh_s7;
			base_s8    <= base_s7;
			lod_s8     <= lod_s7;
			vis_s8     <= vis_s7;
			skel_s8    <= skel_s7;
			scaled_s8  <= prod_s7 * RECIP;
		end
	end

	// ------------------------------------------------------------------
	// s8: saturating add, result register
	// ------------------------------------------------------------------
	assign quot_c = scaled_s8[RECIP_SHIFT +: QUOT_W];
	assign sum_c  = {1'b0, base_s8} + (TIME_W+1)'(quot_c);

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			refreshed_q <= refresh_s8;
			lod_q       <= refresh_s8 ? lod_s8 : '0;
			vis_q       <= refresh_s8 && vis_s8;
			skel_q2     <= refresh_s8 && skel_s8;
			if (!refresh_s8) begin
				next_q <= base_s8;
			end else if (sum_c[TIME_W]) begin
				next_q <= '1;
			end else begin
				next_q <= sum_c[TIME_W-1:0];
			end
		end
	end

	assign out_valid     = vld_q[NSTG-1];
	assign refreshed     = refreshed_q;
	assign lod_level     = lod_q;
	assign visible       = vis_q;
	assign skeletal_on   = skel_q2;
	assign next_due_time = next_q;

endmodule

// File: rtl/dls_checker.sv
// ----------------------------------------------------------------------------
// dls_checker
// Port-level checks on the distance LOD selector, bound to the top level.
// ----------------------------------------------------------------------------
module dls_checker
	import dls_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              refreshed,
	input logic [LOD_W-1:0]  lod_level,
	input logic              visible,
	input logic              skeletal_on,
	input logic [TIME_W-1:0] next_due_time
);

	// held result word does not move
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(refreshed)
			&& $stable(lod_level) && $stable(visible) && $stable(skeletal_on)
			&& $stable(next_due_time)))
		else $error("result word changed while stalled");

	// input only backs up when the result side is full and stalled
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with result side free");

	a_skipped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !refreshed) |-> (lod_level == '0 && !visible && !skeletal_on))
		else $error("skipped entity carries level or flags");

	a_lod_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (lod_level <= LOD_W'(LOD_THRESHOLDS)))
		else $error("level out of range");

	a_skel_vis: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && skeletal_on) |-> (visible && refreshed))
		else $error("skeletal mesh on an invisible entity");

endmodule

bind distance_lod_selector_unit dls_checker u_dls_checker (.*);

// File: dv/distance_lod_selector_unit_tb.sv
// ----------------------------------------------------------------------------
// distance_lod_selector_unit_tb
// Self-checking bench for the distance LOD selector.
// ----------------------------------------------------------------------------
// Entity words stream through a valid/stall driver with random gaps while the
// result side stalls at random. A behavioral predictor computes the expected
// word at acceptance and the monitor checks results in order. Settings are
// rewritten between batches once the pipe is empty: reset values, extremes,
// unsorted thresholds and odd view counts, then random settings.
// ----------------------------------------------------------------------------
module distance_lod_selector_unit_tb;
	import dls_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int STUCK_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [NUM_W-1:0]   num;
		logic               mesh;
		logic [TIME_W-1:0]  due;
		logic [TIME_W-1:0]  now;
	} entity_t;

	typedef struct {
		logic              refreshed;
		logic [LOD_W-1:0]  lod;
		logic              vis;
		logic              skel;
		logic [TIME_W-1:0] next_due;
	} lod_result_t;

	typedef struct {
		logic [4*THR_W-1:0]              thr;
		logic [INTERVAL_SLOTS*IVL_W-1:0] ivl;
		logic [SKEL_W-1:0]               skel;
		logic [MAXVIS_W-1:0]             maxvis;
		logic [VCNT_W-1:0]               vcnt;
		logic [VIEW_W-1:0]               view_a;
		logic [VIEW_W-1:0]               view_b;
	} lod_cfg_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [COORD_W-1:0]    pos_x = '0;
	logic [COORD_W-1:0]    pos_y = '0;
	logic [COORD_W-1:0]    pos_z = '0;
	logic [NUM_W-1:0]      entity_number = '0;
	logic                  has_skeletal_mesh = 1'b0;
	logic [TIME_W-1:0]     due_time = '0;
	logic [TIME_W-1:0]     now_time = '0;

	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  refreshed;
	logic [LOD_W-1:0]      lod_level;
	logic                  visible;
	logic                  skeletal_on;
	logic [TIME_W-1:0]     next_due_time;

	lod_cfg_t    cfg_m = '{RST_LOD_THR, RST_IVL_TAB, RST_SKEL, RST_MAXVIS, RST_VCNT, '0, '0};
	entity_t     entity_queue[$];
	lod_result_t lod_expected[$];
	entity_t     cur_entity;
	lod_result_t want;

	logic calm = 1'b0;
	int   send_gap = 0;
	int   stall_left = 0;
	int   stuck_cycles = 0;
	int   errors = 0;
	int   n_sent = 0;
	int   n_results = 0;
	int   n_skipped = 0;
	int   n_visible = 0;
	int   n_skel = 0;
	int   n_settings = 1;
	int   lod_hist[LOD_THRESHOLDS+1] = '{default: 0};

	distance_lod_selector_unit u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.pos_x             (pos_x),
		.pos_y             (pos_y),
		.pos_z             (pos_z),
		.entity_number     (entity_number),
		.has_skeletal_mesh (has_skeletal_mesh),
		.due_time          (due_time),
		.now_time          (now_time),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.refreshed         (refreshed),
		.lod_level         (lod_level),
		.visible           (visible),
		.skeletal_on       (skeletal_on),
		.next_due_time     (next_due_time)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic lod_result_t select_lod(entity_t e);
		lod_result_t r;
		longint unsigned best, d2, ad, t, q;
		longint d;
		logic [COORD_W-1:0] p [3];
		logic [VIEW_W-1:0] v [2];
		int nv, slot;
		logic [TIME_W:0] nxt;
		r.refreshed = 1'b0;
		r.lod = '0;
		r.vis = 1'b0;
		r.skel = 1'b0;
		r.next_due = e.due;
		if (e.now < e.due) begin
			return r;
		end
		p[0] = e.x;
		p[1] = e.y;
		p[2] = e.z;
		v[0] = cfg_m.view_a;
		v[1] = cfg_m.view_b;
		nv = (cfg_m.vcnt == 0) ? 1 : ((cfg_m.vcnt > MAX_VIEWS) ? MAX_VIEWS : cfg_m.vcnt);
		best = '1;
		for (int i = 0; i < nv; i++) begin
			d2 = 0;
			for (int k = 0; k < 3; k++) begin
				d = longint'(coord_t'(p[k])) - longint'(coord_t'(v[i][COORD_W*k +: COORD_W]));
				ad = (d < 0) ? -d : d;
				d2 += ad * ad;
			end
			if (d2 < best) begin
				best = d2;
			end
		end
		// walk down so the lowest covering threshold wins
		r.lod = LOD_W'(LOD_THRESHOLDS);
		for (int i = LOD_THRESHOLDS - 1; i >= 0; i--) begin
			t = cfg_m.thr[THR_W*i +: THR_W];
			if (best <= t * t) begin
				r.lod = LOD_W'(i);
			end
		end
		t = cfg_m.maxvis;
		r.vis = (t == 0) || (best <= t * t);
		t = cfg_m.skel;
		r.skel = r.vis && e.mesh && (best <= t * t);
		slot = (r.lod > INTERVAL_SLOTS - 1) ? INTERVAL_SLOTS - 1 : int'(r.lod);
		t = cfg_m.ivl[IVL_W*slot +: IVL_W];
		q = t * (JIT_BASE + JIT_STEP * (e.num % JIT_MOD)) / 300;
		nxt = {1'b0, e.now} + q[TIME_W:0];
		r.next_due = nxt[TIME_W] ? '1 : nxt[TIME_W-1:0];
		r.refreshed = 1'b1;
		return r;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic entity_t mk_entity(int x, int y, int z, logic [NUM_W-1:0] num,
		logic mesh, logic [TIME_W-1:0] due, logic [TIME_W-1:0] now);
		entity_t e;
		e.x = COORD_W'(x);
		e.y = COORD_W'(y);
		e.z = COORD_W'(z);
		e.num = num;
		e.mesh = mesh;
		e.due = due;
		e.now = now;
		return e;
	endfunction

	function automatic entity_t rand_entity();
		entity_t e;
		logic [VIEW_W-1:0] v;
		int c [3];
		int r, sel, axis, off;
		v = ($urandom_range(0, 1) == 1) ? cfg_m.view_b : cfg_m.view_a;
		for (int k = 0; k < 3; k++) begin
			c[k] = int'(coord_t'(v[COORD_W*k +: COORD_W]));
		end
		sel = $urandom_range(0, 9);
		if (sel < 2) begin
			for (int k = 0; k < 3; k++) begin
				c[k] = int'(coord_t'(COORD_W'($urandom())));
			end
		end else if (sel < 4) begin
			// land on or next to a boundary distance along one axis
			axis = $urandom_range(0, 2);
			sel = $urandom_range(0, 5);
			if (sel < 4) begin
				off = int'(cfg_m.thr[THR_W*sel +: THR_W]);
			end else if (sel == 4) begin
				off = int'(cfg_m.skel);
			end else begin
				off = int'(cfg_m.maxvis);
			end
			off = off + int'($urandom_range(0, 2)) - 1;
			c[axis] = ($urandom_range(0, 1) == 1) ? c[axis] + off : c[axis] - off;
		end else begin
			r = 1 << $urandom_range(2, 18);
			for (int k = 0; k < 3; k++) begin
				c[k] = c[k] + int'($urandom_range(0, 2 * r)) - r;
			end
		end
		for (int k = 0; k < 3; k++) begin
			if (c[k] < -(1 << (COORD_W - 1))) begin
				c[k] = -(1 << (COORD_W - 1));
			end else if (c[k] > (1 << (COORD_W - 1)) - 1) begin
				c[k] = (1 << (COORD_W - 1)) - 1;
			end
		end
		e.x = COORD_W'(c[0]);
		e.y = COORD_W'(c[1]);
		e.z = COORD_W'(c[2]);
		e.num = $urandom();
		e.mesh = 1'($urandom_range(0, 1));
		sel = $urandom_range(0, 19);
		if (sel < 12) begin
			e.due = $urandom();
			e.now = e.due + $urandom_range(0, 5000);
			if (e.now < e.due) begin
				e.now = '1;
			end
		end else if (sel < 15) begin
			e.now = $urandom();
			e.due = e.now + $urandom_range(1, 3000);
		end else if (sel < 17) begin
			e.now = 32'hFFFF_FFFF - $urandom_range(0, 6000);
			e.due = e.now - $urandom_range(0, 100);
		end else if (sel == 17) begin
			e.now = $urandom();
			e.due = e.now;
		end else begin
			e.now = $urandom();
			e.due = $urandom();
		end
		return e;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_LOD_THR: cfg_m.thr = val[4*THR_W-1:0];
			CFG_IVL_TAB: cfg_m.ivl = val[INTERVAL_SLOTS*IVL_W-1:0];
			CFG_SKEL:    cfg_m.skel = val[SKEL_W-1:0];
			CFG_MAXVIS:  cfg_m.maxvis = val[MAXVIS_W-1:0];
			CFG_VCNT:    cfg_m.vcnt = val[VCNT_W-1:0];
			CFG_VIEW_A:  cfg_m.view_a = val[VIEW_W-1:0];
			CFG_VIEW_B:  cfg_m.view_b = val[VIEW_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (entity_queue.size() != 0 || in_valid || lod_expected.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic run_batch(input int n);
		@(negedge clk);
		calm = ($urandom_range(0, 3) == 0);
		n_settings++;
		repeat (n) entity_queue.push_back(rand_entity());
		drain();
	endtask

	function automatic logic [CFG_DATA_W-1:0] rand_view();
		int c [3];
		for (int k = 0; k < 3; k++) begin
			if ($urandom_range(0, 3) == 0) begin
				c[k] = $urandom();
			end else begin
				c[k] = int'($urandom_range(0, 100000)) - 50000;
			end
		end
		return {1'($urandom()), COORD_W'(c[2]), COORD_W'(c[1]), COORD_W'(c[0])};
	endfunction

	task automatic randomize_settings();
		logic [4*THR_W-1:0] thr;
		int t;
		if ($urandom_range(0, 4) == 0) begin
			thr = {$urandom(), $urandom()};
		end else begin
			t = $urandom_range(0, 3000);
			for (int i = 0; i < LOD_THRESHOLDS; i++) begin
				thr[THR_W*i +: THR_W] = THR_W'(t);
				t = t + int'($urandom_range(0, (65535 - t) / 2));
			end
		end
		write_reg(CFG_LOD_THR, thr);
		write_reg(CFG_IVL_TAB, {$urandom(), $urandom()});
		write_reg(CFG_SKEL, ($urandom_range(0, 1) == 1) ? $urandom_range(0, 4000) : $urandom());
		if ($urandom_range(0, 4) == 0) begin
			write_reg(CFG_MAXVIS, '0);
		end else begin
			write_reg(CFG_MAXVIS, ($urandom_range(0, 1) == 1) ? $urandom_range(1, 20000)
				: {$urandom(), $urandom()});
		end
		write_reg(CFG_VCNT, {$urandom(), $urandom()});
		write_reg(CFG_VIEW_A, rand_view());
		write_reg(CFG_VIEW_B, rand_view());
		if ($urandom_range(0, 3) == 0) begin
			write_reg(CFG_UNUSED, {$urandom(), $urandom()});
		end
	endtask

	// entity driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				lod_expected.push_back(select_lod(cur_entity));
				n_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (entity_queue.size() != 0) begin
					cur_entity = entity_queue.pop_front();
					pos_x <= cur_entity.x;
					pos_y <= cur_entity.y;
					pos_z <= cur_entity.z;
					entity_number <= cur_entity.num;
					has_skeletal_mesh <= cur_entity.mesh;
					due_time <= cur_entity.due;
					now_time <= cur_entity.now;
					in_valid <= 1'b1;
					send_gap <= (!calm && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (lod_expected.size() == 0) begin
					$error("result word with no entity outstanding");
					errors++;
				end else begin
					want = lod_expected.pop_front();
					n_results++;
					if (refreshed !== want.refreshed) begin
						$error("refreshed: expected %0d, got %0d", want.refreshed, refreshed);
						errors++;
					end
					if (lod_level !== want.lod) begin
						$error("lod_level: expected %0d, got %0d", want.lod, lod_level);
						errors++;
					end
					if (visible !== want.vis) begin
						$error("visible: expected %0d, got %0d", want.vis, visible);
						errors++;
					end
					if (skeletal_on !== want.skel) begin
						$error("skeletal_on: expected %0d, got %0d", want.skel, skeletal_on);
						errors++;
					end
					if (next_due_time !== want.next_due) begin
						$error("next_due_time: expected %0d, got %0d", want.next_due,
							next_due_time);
						errors++;
					end
					if (!want.refreshed) begin
						n_skipped++;
					end else begin
						lod_hist[want.lod]++;
						n_visible += want.vis;
						n_skel += want.skel;
					end
				end
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				stall_left <= pick_gap() - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		while (stuck_cycles < STUCK_LIMIT) begin
			@(posedge clk);
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: boundaries of the 500, 1500 and 6000 thresholds and both cutoffs
		@(negedge clk);
		entity_queue.push_back(mk_entity(0, 0, 0, 0, 1'b1, 0, 0));
		entity_queue.push_back(mk_entity(300, 0, 0, 1, 1'b1, 10, 10));
		entity_queue.push_back(mk_entity(301, 0, 0, 2, 1'b1, 10, 11));
		entity_queue.push_back(mk_entity(3, 4, 0, 3, 1'b1, 0, 100));
		entity_queue.push_back(mk_entity(500, 0, 0, 4, 1'b0, 0, 100));
		entity_queue.push_back(mk_entity(0, 501, 0, 5, 1'b1, 0, 100));
		entity_queue.push_back(mk_entity(0, 0, 1500, 6, 1'b1, 0, 100));
		entity_queue.push_back(mk_entity(0, 0, -1501, 7, 1'b1, 0, 100));
		entity_queue.push_back(mk_entity(6000, 0, 0, 15, 1'b1, 0, 100));
		entity_queue.push_back(mk_entity(-6001, 0, 0, 30, 1'b1, 0, 100));
		entity_queue.push_back(mk_entity(10000, 0, 0, 31, 1'b1, 0, 100));
		entity_queue.push_back(mk_entity(-10001, 0, 0, 62, 1'b1, 0, 100));
		entity_queue.push_back(mk_entity(7, 7, 7, 9, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFE));
		entity_queue.push_back(mk_entity(7, 7, 7, 9, 1'b0, 1, 0));
		entity_queue.push_back(mk_entity(-1048576, -1048576, -1048576, 32'hFFFF_FFFF, 1'b1,
			0, 32'hFFFF_FFFF));
		entity_queue.push_back(mk_entity(1048575, 1048575, 1048575, 30, 1'b1, 5, 5));
		entity_queue.push_back(mk_entity(10, -20, 30, 31, 1'b1, 0, 32'hFFFF_FFF0));
		entity_queue.push_back(mk_entity(10, -20, 30, 0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		entity_queue.push_back(mk_entity(2000, 2000, 2000, 32'h8000_0000, 1'b1, 1000, 2000));
		entity_queue.push_back(mk_entity(-4000, 3000, 0, 32'h7FFF_FFFF, 1'b0, 0, 32'h8000_0000));
		drain();

		// everything at its top: all thresholds and intervals saturated, no visibility cutoff
		write_reg(CFG_LOD_THR, '1);
		write_reg(CFG_IVL_TAB, '1);
		write_reg(CFG_SKEL, '1);
		write_reg(CFG_MAXVIS, '0);
		write_reg(CFG_VCNT, 64'hFFFF_FFFF_FFFF_FFFE);
		write_reg(CFG_VIEW_A, {1'b1, {3{21'h100000}}});
		write_reg(CFG_VIEW_B, {1'b0, {3{21'h0FFFFF}}});
		run_batch(30);

		// thresholds, intervals and skeletal cutoff at zero, visibility cutoff at its top; view count of zero behaves as one
		write_reg(CFG_LOD_THR, '0);
		write_reg(CFG_IVL_TAB, '0);
		write_reg(CFG_SKEL, '0);
		write_reg(CFG_MAXVIS, '1);
		write_reg(CFG_VCNT, 64'h4);
		write_reg(CFG_VIEW_A, '0);
		write_reg(CFG_VIEW_B, {1'b0, 21'd500, 21'd500, 21'd500});
		write_reg(CFG_UNUSED, '1);
		run_batch(30);

		// unsorted thresholds, view count above the maximum
		write_reg(CFG_LOD_THR, {16'd60000, 16'd200, 16'd5000, 16'd100});
		write_reg(CFG_IVL_TAB, 60'h001_FFF_800_7FF_ABC);
		write_reg(CFG_SKEL, 16'd1000);
		write_reg(CFG_MAXVIS, 20'd30000);
		write_reg(CFG_VCNT, 64'h3);
		write_reg(CFG_VIEW_A, {1'b0, 21'h1FFF00, 21'd1000, 21'd250});
		write_reg(CFG_VIEW_B, {1'b0, 21'd8000, 21'h1FC000, 21'd12000});
		run_batch(30);

		repeat (12) begin
			randomize_settings();
			run_batch(105);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d entities (%0d not yet due) over %0d register settings, %0d checked",
			n_sent, n_skipped, n_settings, n_results);
		$display("lod levels 0-4: %0d %0d %0d %0d %0d; visible %0d; skeletal %0d",
			lod_hist[0], lod_hist[1], lod_hist[2], lod_hist[3], lod_hist[4], n_visible, n_skel);
		if (errors == 0 && lod_expected.size() == 0) begin
			$display("TB_OK");
		end else begin
			if (lod_expected.size() != 0) begin
				$error("%0d expected result words never arrived", lod_expected.size());
			end
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
